>>> sv/nfcfb_pkg.sv
package nfcfb_pkg;

   localparam int BYTE_W = 8;
   localparam int STEP_W = 3;

   localparam logic [BYTE_W-1:0] PREAMBLE_LO   = 8'h00;
   localparam logic [BYTE_W-1:0] PREAMBLE_HI   = 8'hFF;
   localparam logic [BYTE_W-1:0] POSTAMBLE     = 8'h00;
   localparam logic [BYTE_W-1:0] TFI_RESET     = 8'hD4;
   localparam logic [BYTE_W-1:0] LEN_MIN       = 8'd1;
   localparam logic [BYTE_W-1:0] LEN_MAX       = 8'd254;
   localparam logic [BYTE_W-1:0] LEN_OVER      = 8'd255;

   // Kind of work the back end carries out for one accepted item.
   localparam logic [1:0] KIND_FIRST  = 2'd0;  // header plus first payload byte
   localparam logic [1:0] KIND_MIDDLE = 2'd1;  // payload byte only
   localparam logic [1:0] KIND_LAST   = 2'd2;  // payload byte, checksum, postamble
   localparam logic [1:0] KIND_TAIL   = 2'd3;  // checksum and postamble only

   // Step at which each kind emits its final byte.
   localparam logic [STEP_W-1:0] FIRST_END_STEP  = 3'd6;
   localparam logic [STEP_W-1:0] MIDDLE_END_STEP = 3'd0;
   localparam logic [STEP_W-1:0] LAST_END_STEP   = 3'd2;
   localparam logic [STEP_W-1:0] TAIL_END_STEP   = 3'd1;

   // Header steps of a first byte.
   localparam logic [STEP_W-1:0] STEP_PRE0 = 3'd0;
   localparam logic [STEP_W-1:0] STEP_PRE1 = 3'd1;
   localparam logic [STEP_W-1:0] STEP_PRE2 = 3'd2;
   localparam logic [STEP_W-1:0] STEP_LEN  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LCS  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_TFI  = 3'd5;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] payload_len;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
      logic              frame_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] len_byte;
      logic [BYTE_W-1:0] tfi;
      logic [BYTE_W-1:0] dcs;
   } cmd_type;

endpackage

>>> sv/nfcfb_front.sv
module nfcfb_front import nfcfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        accept,
   input  req_type     req_data,
   output cmd_type     cmd
);

   logic              in_frame_ff, in_frame_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] tfi_ff, tfi_in;
   logic [BYTE_W-1:0] len_clamped;
   logic [BYTE_W-1:0] sum_next;
   logic [BYTE_W-1:0] left_next;

   always_comb begin
      len_clamped = req_data.payload_len;
      if (req_data.payload_len == 8'd0) begin
         len_clamped = LEN_MIN;
      end else if (req_data.payload_len == LEN_OVER) begin
         len_clamped = LEN_MAX;
      end

      sum_next  = sum_ff + req_data.payload_byte;
      left_next = bytes_left_ff - 8'd1;

      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      tfi_in        = csr_wr_en ? csr_wr_data : tfi_ff;

      cmd.data     = req_data.payload_byte;
      cmd.len_byte = len_clamped + 8'd1;
      cmd.tfi      = tfi_ff;
      cmd.dcs      = (~sum_next) + 8'd1;
      cmd.kind     = KIND_FIRST;

      if (!in_frame_ff) begin
         cmd.kind      = KIND_FIRST;
         sum_in        = tfi_ff + req_data.payload_byte;
         bytes_left_in = len_clamped - 8'd1;
         in_frame_in   = 1'b1;
      end else if (bytes_left_ff == 8'd0) begin
         // A one-byte frame closes on the item after its first byte.
         cmd.kind      = KIND_TAIL;
         cmd.dcs       = (~sum_ff) + 8'd1;
         in_frame_in   = 1'b0;
      end else begin
         sum_in        = sum_next;
         bytes_left_in = left_next;
         if (left_next != 8'd0) begin
            cmd.kind = KIND_MIDDLE;
         end else begin
            cmd.kind    = KIND_LAST;
            in_frame_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= '0;
         sum_ff        <= '0;
         tfi_ff        <= TFI_RESET;
      end else begin
         tfi_ff <= tfi_in;
         if (accept) begin
            in_frame_ff   <= in_frame_in;
            bytes_left_ff <= bytes_left_in;
            sum_ff        <= sum_in;
         end
      end
   end

endmodule

>>> sv/nfcfb_queue.sv
module nfcfb_queue import nfcfb_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/nfcfb_back.sv
module nfcfb_back import nfcfb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type q_data,
   input  logic    q_empty,
   output logic    q_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty,
   input  logic    rsp_pop
);

   logic              cur_valid_ff, cur_valid_in;
   cmd_type           cur_ff, cur_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic [STEP_W-1:0] end_step;
   logic              at_end;
   logic              emit;
   logic              load;
   rsp_type           sel;

   always_comb begin
      case (cur_ff.kind)
         KIND_FIRST:  end_step = FIRST_END_STEP;
         KIND_MIDDLE: end_step = MIDDLE_END_STEP;
         KIND_LAST:   end_step = LAST_END_STEP;
         default:     end_step = TAIL_END_STEP;
      endcase
      at_end = (step_ff == end_step);

      sel.last_of_run = at_end;
      sel.frame_end   = 1'b0;
      sel.out_byte    = cur_ff.data;
      case (cur_ff.kind)
         KIND_FIRST: begin
            case (step_ff)
               STEP_PRE0: sel.out_byte = PREAMBLE_LO;
               STEP_PRE1: sel.out_byte = PREAMBLE_LO;
               STEP_PRE2: sel.out_byte = PREAMBLE_HI;
               STEP_LEN:  sel.out_byte = cur_ff.len_byte;
               STEP_LCS:  sel.out_byte = (~cur_ff.len_byte) + 8'd1;
               STEP_TFI:  sel.out_byte = cur_ff.tfi;
               default:   sel.out_byte = cur_ff.data;
            endcase
         end
         KIND_MIDDLE: begin
            sel.out_byte = cur_ff.data;
         end
         KIND_LAST: begin
            if (step_ff == 3'd0) begin
               sel.out_byte = cur_ff.data;
            end else if (step_ff == 3'd1) begin
               sel.out_byte = cur_ff.dcs;
            end else begin
               sel.out_byte  = POSTAMBLE;
               sel.frame_end = 1'b1;
            end
         end
         default: begin
            if (step_ff == 3'd0) begin
               sel.out_byte = cur_ff.dcs;
            end else begin
               sel.out_byte  = POSTAMBLE;
               sel.frame_end = 1'b1;
            end
         end
      endcase
   end

   assign emit  = cur_valid_ff && (!out_valid_ff || rsp_pop);
   assign load  = !cur_valid_ff || (emit && at_end);
   assign q_pop = load && !q_empty;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = sel;
         step_in      = step_ff + 1'b1;
      end
      if (load) begin
         cur_valid_in = !q_empty;
         cur_in       = q_data;
         step_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      cur_ff <= cur_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

>>> sv/nfc_host_frame_builder.sv
// Host-to-module NFC information frame builder. Payload bytes enter one per
// transfer on the req_ side; the first byte of a frame also carries the payload
// count (0 is taken as 1, 255 as 254). The rsp_ side delivers the framed byte
// stream for a serial transmitter: the first byte yields seven bytes (00 00 FF,
// LEN, length checksum, the direction byte from csr_wr_data, the payload byte),
// middle bytes yield one byte, and the final byte yields three (itself, the
// data checksum over direction byte and payload, postamble 00). A one-byte
// frame is closed by the next input transfer, whose fields are ignored and
// which yields only the checksum and postamble. The direction byte resets to
// D4 and is sampled at the first byte of each frame. A front end classifies
// each input and keeps the frame state; it accepts one input per clock while
// the command queue (QUEUE_DEPTH entries) has room. A back-end sequencer then
// emits one output byte per clock into a registered output stage while that
// stage is empty or being popped, and the sustained rate is one rsp_ byte per
// clock when rsp_pop stays high.
module nfc_host_frame_builder import nfcfb_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   cmd_type front_cmd;
   cmd_type q_data;
   logic    q_empty;
   logic    q_pop;
   logic    accept;

   // An input transfer completes whenever the queue has a free slot.
   assign accept = req_push && !req_full;

   nfcfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req_data    (req_data),
      .cmd         (front_cmd)
   );

   nfcfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // The back end drains commands independently of the input side.
   nfcfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

>>> sv/nfcfb_checker.sv
module nfcfb_checker import nfcfb_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input rsp_type    rsp_data
);

   // A stalled result must hold until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // The postamble closes both the frame and the run of its input.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_end) |->
         (rsp_data.last_of_run && rsp_data.out_byte == POSTAMBLE))
      else $error("bad postamble");

   // Reset leaves no result waiting and room for input.
   assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("state not cleared by reset");

   // After a byte that does not end its run is taken, the result shown next is flagged
   // only if it carries frame_end and the taken byte was a postamble with frame_end set.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_of_run) |=> !rsp_data.frame_end ||
         rsp_empty || $past(rsp_data.out_byte) != POSTAMBLE ||
         $past(rsp_data.frame_end) == 1'b0)
      else $error("frame end out of order");

endmodule

bind nfc_host_frame_builder nfcfb_checker u_nfcfb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_full    (req_full),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_data    (rsp_data)
);
